// ===== rtl/core/bscd_pkg.sv =====
// bscd_pkg: widths, limits and register codes shared by the BiSS-C frame decoder,
// its channel interfaces and its checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bscd_pkg;

  localparam int FrameW   = 64;  // raw frame word
  localparam int PosW     = 30;  // widest single-turn position
  localparam int WordW    = 32;  // turns, positions, counters
  localparam int CrcW     = 6;
  localparam int DataW    = PosW + 2;  // position, error and warning bits
  localparam int NbW      = 5;   // data_bits register
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 30;

  localparam logic [NbW-1:0] NbMin   = 5'd1;
  localparam logic [NbW-1:0] NbMax   = 5'd30;
  localparam logic [NbW-1:0] NbReset = 5'd22;

  // Frame overhead kept after alignment: start, CDS, error, warning, CRC6.
  localparam int FrameOvh = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDataBits = 2'd0,
    CfgInvert   = 2'd1,
    CfgOffset   = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/core/bscd_if.sv =====
// Valid/ready channel interfaces of the BiSS-C frame decoder: raw frame in,
// decoded result out. Depends on bscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bscd_in_if;
  import bscd_pkg::*;

  logic              valid;
  logic              ready;
  logic [FrameW-1:0] frame_bits;

  modport source (output valid, output frame_bits, input ready);
  modport sink   (input valid, input frame_bits, output ready);
endinterface

interface bscd_out_if;
  import bscd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    crc_good;
  logic [PosW-1:0]         single_turn;
  logic                    error_bit;
  logic                    warning_bit;
  logic signed [WordW-1:0] turns;
  logic signed [WordW-1:0] absolute_position;
  logic signed [WordW-1:0] offset_position;
  logic [WordW-1:0]        bad_frames;

  modport source (
    output valid, output crc_good, output single_turn, output error_bit,
    output warning_bit, output turns, output absolute_position,
    output offset_position, output bad_frames, input ready
  );
  modport sink (
    input valid, input crc_good, input single_turn, input error_bit,
    input warning_bit, input turns, input absolute_position,
    input offset_position, input bad_frames, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/bscd_crc6.sv =====
// bscd_crc6: inverted CRC-6 (x^6+x+1, seed 0, MSB first) check over the
// position/error/warning field. Depends on bscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bscd_crc6 (
  input  logic [bscd_pkg::DataW-1:0] data_i,
  input  logic [bscd_pkg::CrcW-1:0]  crc_rx_i,
  output logic                       good_o
);
  import bscd_pkg::*;

  localparam logic [CrcW-1:0] CrcPoly = 6'h03;

  logic [CrcW-1:0] crc;
  logic            fb;

  // Unused upper bits are zero; with a zero seed they leave the CRC at zero.
  always_comb begin
    crc = '0;
    fb  = 1'b0;
    for (int i = DataW - 1; i >= 0; i--) begin
      fb  = crc[CrcW-1] ^ data_i[i];
      crc = {crc[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    good_o = (~crc == crc_rx_i);
  end

endmodule

`default_nettype wire

// ===== rtl/core/biss_c_frame_decoder.sv =====
// biss_c_frame_decoder: BiSS-C frame alignment, CRC-6 check and multiturn tracking;
// depends on bscd_pkg, bscd_if and bscd_crc6.
// Path: an accepted frame beat moves from the input register into the result register.
// Throughput: one frame per cycle while result_o.ready is high; input and result register each hold one beat.
// Reset: rst_ni (async, active low) clears both valids, tracking state, the
//   bad-frame counter and the config registers (data_bits = 22, others 0).
`timescale 1ns / 1ps
`default_nettype none

module biss_c_frame_decoder #(
  parameter int FRAME_WIDTH = 64  // 40..64 leading bits of frame_bits are used
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bscd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bscd_pkg::CfgDataW-1:0] cfg_data_i,
  bscd_in_if.sink                       frame_i,
  bscd_out_if.source                    result_o
);
  import bscd_pkg::*;

  localparam int LzW  = $clog2(FrameW + 1);
  localparam int ShW  = $clog2(FrameW);
  localparam int AlnW = FrameW - 2;  // aligned word after dropping two bits

  // Only the top FRAME_WIDTH bits of the raw word are meaningful.
  localparam logic [FrameW-1:0] KeepMask = ~({FrameW{1'b1}} >> FRAME_WIDTH);

  // Leading-zero count; FrameW for an all-zero word.
  function automatic logic [LzW-1:0] lzc(input logic [FrameW-1:0] v);
    logic [LzW-1:0] n;
    n = LzW'(FrameW);
    for (int i = 0; i < FrameW; i++) begin
      if (v[i]) n = LzW'(FrameW - 1 - i);
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [NbW-1:0]  data_bits_q;
  logic            invert_q;
  logic [PosW-1:0] offset_q;
  logic [NbW-1:0]  nb;  // clamped resolution, 1..30

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= NbReset;
      invert_q    <= 1'b0;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDataBits: data_bits_q <= cfg_data_i[NbW-1:0];
        CfgInvert:   invert_q    <= cfg_data_i[0];
        CfgOffset:   offset_q    <= cfg_data_i[PosW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    priority if (data_bits_q < NbMin) nb = NbMin;
    else if (data_bits_q > NbMax)     nb = NbMax;
    else                              nb = data_bits_q;
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register and result register, each with a valid bit.
  // A register advances when empty or when the one after it advances; the
  // result register drains on result_o.ready.
  // ---------------------------------------------------------------------------
  logic in_vld_q;
  logic out_vld_q;
  logic out_adv;
  logic in_adv;
  logic in_load;
  logic out_load;

  assign out_adv  = !out_vld_q || result_o.ready;
  assign in_adv   = !in_vld_q || out_adv;
  assign in_load  = in_adv && frame_i.valid;
  assign out_load = out_adv && in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_adv)  in_vld_q  <= frame_i.valid;
      if (out_adv) out_vld_q <= in_vld_q;
    end
  end

  assign frame_i.ready = in_adv;

  // Input register: the frame beat, cut to FRAME_WIDTH bits
  logic [FrameW-1:0] frame_q;

  always_ff @(posedge clk_i) begin
    if (in_load) frame_q <= frame_i.frame_bits & KeepMask;
  end

  // ---------------------------------------------------------------------------
  // Alignment: left-justify on the first 1, drop it and the bit after it, then
  // right-shift so the top data_bits+10 bits remain. A word shorter than that
  // is left where it is.
  // ---------------------------------------------------------------------------
  logic [LzW-1:0]    lz_first;
  logic [FrameW-1:0] norm;
  logic [AlnW-1:0]   aligned;
  logic [LzW-1:0]    lz_rest;
  logic [LzW-1:0]    len;
  logic [LzW-1:0]    keep;
  logic [AlnW-1:0]   kept;

  assign lz_first = lzc(frame_q);
  assign norm     = frame_q << lz_first[ShW-1:0];  // all-zero word stays zero
  assign aligned  = norm[AlnW-1:0];
  assign lz_rest  = lzc({2'b00, aligned});
  assign len      = LzW'(FrameW) - lz_rest;
  assign keep     = LzW'(nb) + LzW'(FrameOvh);
  assign kept     = (len >= keep) ? (aligned >> ShW'(len - keep)) : aligned;

  // Split into received CRC and the position/error/warning field
  logic [WordW:0]   dmask;
  logic [DataW-1:0] data;
  logic [CrcW-1:0]  crc_rx;
  logic             good;
  logic [PosW-1:0]  pos;

  assign dmask  = ((WordW+1)'(1) << (6'(nb) + 6'd2)) - (WordW+1)'(1);
  assign crc_rx = kept[CrcW-1:0];
  assign data   = kept[CrcW +: DataW] & dmask[DataW-1:0];
  assign pos    = data[DataW-1:2];

  bscd_crc6 u_crc6 (
    .data_i   (data),
    .crc_rx_i (crc_rx),
    .good_o   (good)
  );

  // ---------------------------------------------------------------------------
  // Tracking state. Updated as a frame moves into the result register; the
  // state registers are part of the result, so a stalled result keeps them.
  // ---------------------------------------------------------------------------
  logic [PosW-1:0]  cur_q, cur_d;
  logic [PosW-1:0]  prev_q, prev_d;
  logic [WordW-1:0] turns_q, turns_d;
  logic             seen_q, seen_d;
  logic [WordW-1:0] bad_q, bad_d;
  logic [PosW-1:0]  prev_ref;
  logic [PosW-1:0]  half;
  logic signed [WordW-1:0] diff;
  logic signed [WordW-1:0] half_s;

  always_comb begin
    cur_d    = cur_q;
    prev_d   = prev_q;
    turns_d  = turns_q;
    seen_d   = seen_q;
    bad_d    = bad_q;
    // first good frame is measured against the configured offset
    prev_ref = seen_q ? prev_q : offset_q;
    half     = PosW'(1) << (nb - NbW'(1));
    half_s   = $signed({2'b00, half});
    diff     = $signed({2'b00, pos}) - $signed({2'b00, prev_ref});
    if (good) begin
      cur_d  = pos;
      prev_d = pos;
      seen_d = 1'b1;
      // a jump of more than half a turn is a wrap through zero
      priority if (diff > half_s) turns_d = turns_q - WordW'(1);
      else if (-diff > half_s)    turns_d = turns_q + WordW'(1);
    end else if (bad_q != '1) begin
      bad_d = bad_q + WordW'(1);  // saturating
    end
  end

  // Turn-extended position, then direction and offset
  logic [WordW-1:0] pos_sum;
  logic [WordW-1:0] abs_pos, off_pos;

  assign pos_sum = WordW'(cur_d) + (turns_d << nb);

  always_comb begin
    if (invert_q) begin
      abs_pos = WordW'(0) - pos_sum;
      off_pos = WordW'(offset_q) - pos_sum;  // -sum + offset
    end else begin
      abs_pos = pos_sum;
      off_pos = pos_sum - WordW'(offset_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             good_q, err_q, warn_q;
  logic [WordW-1:0] abs_q, off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      prev_q  <= '0;
      turns_q <= '0;
      seen_q  <= 1'b0;
      bad_q   <= '0;
    end else if (out_load) begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      turns_q <= turns_d;
      seen_q  <= seen_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      good_q <= good;
      err_q  <= data[1];
      warn_q <= data[0];
      abs_q  <= abs_pos;
      off_q  <= off_pos;
    end
  end

  assign result_o.valid             = out_vld_q;
  assign result_o.crc_good          = good_q;
  assign result_o.single_turn       = cur_q;
  assign result_o.error_bit         = err_q;
  assign result_o.warning_bit       = warn_q;
  assign result_o.turns             = $signed(turns_q);
  assign result_o.absolute_position = $signed(abs_q);
  assign result_o.offset_position   = $signed(off_q);
  assign result_o.bad_frames        = bad_q;

endmodule

`default_nettype wire

// ===== rtl/core/bscd_checker.sv =====
// bscd_checker: port-level checks on the decoder's result beats, bound to
// biss_c_frame_decoder. Depends on bscd_pkg and bscd_if.
`timescale 1ns / 1ps
`default_nettype none

module bscd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  bscd_out_if.source  result_o
);
  import bscd_pkg::*;

  logic                    out_acc;
  logic                    have_q;
  logic [WordW-1:0]        bad_prev_q;
  logic [PosW-1:0]         st_prev_q;
  logic signed [WordW-1:0] turns_prev_q;

  assign out_acc = result_o.valid && result_o.ready;

  // remember the last delivered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      bad_prev_q   <= '0;
      st_prev_q    <= '0;
      turns_prev_q <= '0;
    end else if (out_acc) begin
      have_q       <= 1'b1;
      bad_prev_q   <= result_o.bad_frames;
      st_prev_q    <= result_o.single_turn;
      turns_prev_q <= result_o.turns;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=>
      result_o.valid && $stable(result_o.bad_frames) && $stable(result_o.offset_position))
    else $error("result beat changed while stalled");

  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !have_q |->
      result_o.bad_frames == (result_o.crc_good ? 32'd0 : 32'd1))
    else $error("first bad-frame count wrong");

  a_good_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q && result_o.crc_good |-> result_o.bad_frames == bad_prev_q)
    else $error("bad-frame count moved on a good frame");

  a_bad_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q && !result_o.crc_good |->
      (result_o.bad_frames == bad_prev_q + 32'd1) ||
      (bad_prev_q == 32'hFFFF_FFFF && result_o.bad_frames == bad_prev_q))
    else $error("bad-frame count not advanced on a bad frame");

  a_bad_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && have_q && !result_o.crc_good |->
      result_o.single_turn == st_prev_q && result_o.turns == turns_prev_q)
    else $error("position tracking moved on a bad frame");

endmodule

bind biss_c_frame_decoder bscd_checker u_bscd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .result_o (result_o)
);

`default_nettype wire
